### hdl/mssc_pkg.sv
// Shared types, constants and the segment table of the scan controller.
`timescale 1ns / 1ps

package mssc_pkg;

  // Request opcodes.
  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_NUMBER   = 2'd1,
    FUNC_LEDS     = 2'd2,
    FUNC_TAKE_KEY = 2'd3
  } func_t;

  // Key codes as reported by a take-key request.
  localparam logic [2:0] KEY_NONE = 3'd0;
  localparam logic [2:0] KEY_CH0  = 3'd1;
  localparam logic [2:0] KEY_CH7  = 3'd2;
  localparam logic [2:0] KEY_CH8  = 3'd3;
  localparam logic [2:0] KEY_CH9  = 3'd4;

  localparam int NUM_BYTES    = 9;
  localparam int NUM_CHANNELS = 10;
  localparam int LED_BYTE     = 8;
  localparam int BANK_DIGITS  = 4;

  localparam logic [3:0] LAST_CHANNEL = 4'(NUM_CHANNELS - 1);
  localparam logic [3:0] CH_KEY0      = 4'd0;
  localparam logic [3:0] CH_KEY7      = 4'd7;
  localparam logic [3:0] CH_KEY8      = 4'd8;
  localparam logic [3:0] CH_KEY9      = 4'd9;

  localparam logic [13:0] MAX_NUMBER = 14'd9999;
  localparam logic [7:0]  BLANK      = 8'h00;

  // Lamp bit positions inside the indicator byte.
  localparam int LED_ONE_BIT   = 7;
  localparam int LED_TWO_BIT   = 6;
  localparam int LED_THREE_BIT = 3;
  localparam int LED_FOUR_BIT  = 1;

  typedef logic [BANK_DIGITS-1:0][7:0] bank_codes_t;

  // Result of the number encoder: whether the value is shown, and its codes.
  typedef struct packed {
    logic        in_range;
    bank_codes_t codes;
  } enc_out_t;

  // One result as it sits in the output register.
  typedef struct packed {
    logic       drive_valid;
    logic [7:0] shift_byte;
    logic [3:0] digit_select;
    logic [2:0] key_code;
  } rsp_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'hED;
      4'd1:    code = 8'h21;
      4'd2:    code = 8'h8F;
      4'd3:    code = 8'hAB;
      4'd4:    code = 8'h63;
      4'd5:    code = 8'hEA;
      4'd6:    code = 8'hEE;
      4'd7:    code = 8'hA1;
      4'd8:    code = 8'hEF;
      4'd9:    code = 8'hEB;
      default: code = BLANK;
    endcase
    return code;
  endfunction

endpackage

### hdl/mssc_if.sv
// Request and result channel interfaces of the scan controller.
`timescale 1ns / 1ps

interface mssc_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [15:0] number_value;
  logic               bank;
  logic               led_one;
  logic               led_two;
  logic               led_three;
  logic               led_four;
  logic               switch_pressed;

  modport source (
    output valid, func, number_value, bank, led_one, led_two, led_three, led_four,
           switch_pressed,
    input  ready
  );
  modport sink (
    input  valid, func, number_value, bank, led_one, led_two, led_three, led_four,
           switch_pressed,
    output ready
  );
endinterface

interface mssc_rsp_if;
  logic       valid;
  logic       ready;
  logic       drive_valid;
  logic [7:0] shift_byte;
  logic [3:0] digit_select;
  logic [2:0] key_code;

  modport source (
    output valid, drive_valid, shift_byte, digit_select, key_code,
    input  ready
  );
  modport sink (
    input  valid, drive_valid, shift_byte, digit_select, key_code,
    output ready
  );
endinterface

### hdl/mssc_num_enc.sv
// Turns a signed 16-bit number into four blanked seven-segment codes.
`timescale 1ns / 1ps

module mssc_num_enc (
  input  logic signed [15:0] number_value,
  output mssc_pkg::enc_out_t enc
);

  logic [13:0] val;
  logic [26:0] p10;
  logic [26:0] p100;
  logic [28:0] p1000;
  logic [9:0]  q10;
  logic [6:0]  q100;
  logic [3:0]  q1000;
  logic [13:0] t10;
  logic [9:0]  t100;
  logic [6:0]  t1000;
  logic [3:0]  d0;
  logic [3:0]  d1;
  logic [3:0]  d2;
  logic [3:0]  d3;

  assign val = number_value[13:0];

  // Constant reciprocals; each quotient is exact for values up to 9999.
  assign p10   = {13'd0, val} * 27'd6554;
  assign p100  = {13'd0, val} * 27'd5243;
  assign p1000 = {15'd0, val} * 29'd16778;
  assign q10   = p10[25:16];
  assign q100  = p100[25:19];
  assign q1000 = p1000[27:24];

  // Times ten as shift and add, then the remainders give the digits.
  assign t10   = {1'b0, q10, 3'b000} + {3'b000, q10, 1'b0};
  assign t100  = {q100, 3'b000} + {2'b00, q100, 1'b0};
  assign t1000 = {q1000, 3'b000} + {2'b00, q1000, 1'b0};
  assign d0    = 4'(val - t10);
  assign d1    = 4'(q10 - t100);
  assign d2    = 4'(q100 - t1000);
  assign d3    = q1000;

  always_comb begin
    enc.in_range = !number_value[15] && (number_value[14] == 1'b0) && (val <= mssc_pkg::MAX_NUMBER);
    enc.codes[0] = mssc_pkg::seg_code(d0);
    enc.codes[1] = (val > 14'd9)   ? mssc_pkg::seg_code(d1) : mssc_pkg::BLANK;
    enc.codes[2] = (val > 14'd99)  ? mssc_pkg::seg_code(d2) : mssc_pkg::BLANK;
    enc.codes[3] = (val > 14'd999) ? mssc_pkg::seg_code(d3) : mssc_pkg::BLANK;
  end

endmodule

### hdl/mux_seven_segment_scan_controller_unit.sv
// Top level of the multiplexed seven-segment display and key-scan controller.
`timescale 1ns / 1ps

// The controller keeps nine display bytes (bottom number in bytes 0-3 with the
// units digit in byte 0, top number in bytes 4-7, indicator lamps in byte 8),
// a scan channel counter and the last key seen. Every request gives exactly one
// result. A scan tick returns the byte of the current channel, to be shifted out
// MSB first, with the channel number for the decoder, samples the key sense line
// on channels 0, 7, 8 and 9, and steps the channel 0..9 with wrap; channel nine
// has no byte of its own and sends all segments dark. A write-number request
// shows 0..9999 with leading blanks in the chosen bank and leaves the display
// alone for any other value. A set-LEDs request sets or clears the four lamp
// bits. A take-key request returns the stored key and clears it. Throughput is
// one request per clock while ready is high: all work is a single pass of logic
// between the request port and the result register, the slowest part being the
// constant-reciprocal digit split of the number. Each result is registered in
// the output register; behind it sits one skid entry, so a stalled result still
// lets one more request in; ready falls only while both are occupied.

module mux_seven_segment_scan_controller_unit (
  input  logic              clk,
  input  logic              rst,
  mssc_req_if.sink          req,
  mssc_rsp_if.source        rsp
);

  // Display storage and scan state.
  logic [7:0] display_bytes [mssc_pkg::NUM_BYTES];
  logic [3:0] scan_index;
  logic [2:0] pressed_key;

  // Output register and skid entry.
  mssc_pkg::rsp_t out_data;
  logic           out_valid;
  mssc_pkg::rsp_t skid_data;
  logic           skid_valid;

  mssc_pkg::func_t   func;
  mssc_pkg::enc_out_t enc;
  mssc_pkg::rsp_t    result;
  logic              accept;
  logic              out_fire;
  logic [3:0]        channel;
  logic [3:0]        scan_index_next;
  logic [2:0]        pressed_key_next;

  assign func     = mssc_pkg::func_t'(req.func);
  assign accept   = req.valid && req.ready;
  assign out_fire = out_valid && rsp.ready;

  assign req.ready        = !skid_valid;
  assign rsp.valid        = out_valid;
  assign rsp.drive_valid  = out_data.drive_valid;
  assign rsp.shift_byte   = out_data.shift_byte;
  assign rsp.digit_select = out_data.digit_select;
  assign rsp.key_code     = out_data.key_code;

  mssc_num_enc u_num_enc (
    .number_value (req.number_value),
    .enc          (enc)
  );

  // A counter value past the last channel cannot arise, but is treated as zero.
  assign channel = (scan_index > mssc_pkg::LAST_CHANNEL) ? 4'd0 : scan_index;
  assign scan_index_next = (channel == mssc_pkg::LAST_CHANNEL) ? 4'd0 : channel + 4'd1;

  // Result of the request now at the port, and the key register's next value.
  always_comb begin
    result           = '0;
    pressed_key_next = pressed_key;
    case (func)
      mssc_pkg::FUNC_TICK: begin
        result.drive_valid  = 1'b1;
        result.digit_select = channel;
        result.shift_byte   = (channel < 4'(mssc_pkg::NUM_BYTES)) ?
                              display_bytes[channel] : mssc_pkg::BLANK;
        if (req.switch_pressed) begin
          case (channel)
            mssc_pkg::CH_KEY0: pressed_key_next = mssc_pkg::KEY_CH0;
            mssc_pkg::CH_KEY7: pressed_key_next = mssc_pkg::KEY_CH7;
            mssc_pkg::CH_KEY8: pressed_key_next = mssc_pkg::KEY_CH8;
            mssc_pkg::CH_KEY9: pressed_key_next = mssc_pkg::KEY_CH9;
            default:           pressed_key_next = pressed_key;
          endcase
        end
      end
      mssc_pkg::FUNC_TAKE_KEY: begin
        result.key_code  = pressed_key;
        pressed_key_next = mssc_pkg::KEY_NONE;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  // Block state changes when a request is accepted; results queue behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mssc_pkg::NUM_BYTES; i++) begin
        display_bytes[i] <= '0;
      end
      scan_index  <= '0;
      pressed_key <= mssc_pkg::KEY_NONE;
    end else if (accept) begin
      pressed_key <= pressed_key_next;
      case (func)
        mssc_pkg::FUNC_TICK: begin
          scan_index <= scan_index_next;
        end
        mssc_pkg::FUNC_NUMBER: begin
          if (enc.in_range) begin
            for (int i = 0; i < mssc_pkg::BANK_DIGITS; i++) begin
              if (req.bank) begin
                display_bytes[mssc_pkg::BANK_DIGITS + i] <= enc.codes[i];
              end else begin
                display_bytes[i] <= enc.codes[i];
              end
            end
          end
        end
        mssc_pkg::FUNC_LEDS: begin
          display_bytes[mssc_pkg::LED_BYTE][mssc_pkg::LED_ONE_BIT]   <= req.led_one;
          display_bytes[mssc_pkg::LED_BYTE][mssc_pkg::LED_TWO_BIT]   <= req.led_two;
          display_bytes[mssc_pkg::LED_BYTE][mssc_pkg::LED_THREE_BIT] <= req.led_three;
          display_bytes[mssc_pkg::LED_BYTE][mssc_pkg::LED_FOUR_BIT]  <= req.led_four;
        end
        default: begin
          scan_index <= scan_index;
        end
      endcase
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || out_fire) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

endmodule
